>>> design/bdc_pkg.sv
// Package for the business day counter: payload types, constants and table functions.
`timescale 1ns / 1ps
package bdc_pkg;

  // Input transfer: the two dates of the span.
  typedef struct packed {
    logic [13:0] from_year;
    logic [3:0]  from_month;
    logic [4:0]  from_day;
    logic [13:0] to_year;
    logic [3:0]  to_month;
    logic [4:0]  to_day;
  } bdc_in_t;

  // Result transfer.
  typedef struct packed {
    logic [21:0] business_days;
    logic [2:0]  from_weekday;
    logic [2:0]  to_weekday;
  } bdc_out_t;

  // Per-date partial result handed from the date unit to the top level.
  typedef struct packed {
    logic [21:0] serial;
    logic [13:0] wsum;
  } bdc_date_t;

  localparam logic [13:0] YEAR_MIN      = 14'd1;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [3:0]  MONTH_MIN     = 4'd1;
  localparam logic [3:0]  MONTH_MAX     = 4'd12;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [4:0]  DAY_MIN       = 5'd1;
  localparam logic [6:0]  MASK_RESET    = 7'd96;
  localparam logic [21:0] DAYS_PER_YEAR = 22'd365;

  // Reciprocal constants: floor(x / 25) for x < 16384, floor(x / 7) for
  // x < 13107 and floor(x / 7) for x < 2^22.
  localparam logic [26:0] RECIP25       = 27'd5243;
  localparam int          RECIP25_SHIFT = 17;
  localparam logic [27:0] RECIP7_S      = 28'd9363;
  localparam int          RECIP7_S_SHIFT = 16;
  localparam logic [44:0] RECIP7_W      = 45'd4793491;
  localparam int          RECIP7_W_SHIFT = 25;

  // Length of a month, February depending on the leap flag.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term of the weekday formula, (31 * m') / 12 with a March-based m'.
  function automatic logic [4:0] wday_month_term(input logic [3:0] m);
    logic [4:0] t;
    case (m)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // Month term of the day serial, (153 * m' + 2) / 5 with a March-based m'.
  function automatic logic [8:0] serial_month_term(input logic [3:0] m);
    logic [8:0] t;
    case (m)
      4'd1:    t = 9'd306;
      4'd2:    t = 9'd337;
      4'd3:    t = 9'd0;
      4'd4:    t = 9'd31;
      4'd5:    t = 9'd61;
      4'd6:    t = 9'd92;
      4'd7:    t = 9'd122;
      4'd8:    t = 9'd153;
      4'd9:    t = 9'd184;
      4'd10:   t = 9'd214;
      4'd11:   t = 9'd245;
      4'd12:   t = 9'd275;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // Number of business days in a whole week.
  function automatic logic [2:0] week_days(input logic [6:0] mask);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (!mask[i]) cnt = cnt + 3'd1;
    end
    return cnt;
  endfunction

  // Business days among the r days that start on weekday wf (r below seven).
  function automatic logic [2:0] rem_count(input logic [2:0] wf, input logic [2:0] r,
                                           input logic [6:0] mask);
    logic [2:0] cnt;
    logic [3:0] w;
    cnt = 3'd0;
    for (int i = 0; i < 6; i++) begin
      w = 4'(wf) + 4'(i);
      if (w >= 4'd7) w = w - 4'd7;
      if ((3'(i) < r) && !mask[w[2:0]]) cnt = cnt + 3'd1;
    end
    return cnt;
  endfunction

endpackage

>>> design/bdc_date.sv
// Date unit: clamps one date and forms its day serial and weekday sum over three stages.
`timescale 1ns / 1ps
module bdc_date (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [13:0]         year,
  input  logic [3:0]          month,
  input  logic [4:0]          day,
  output logic                out_valid,
  output bdc_pkg::bdc_date_t  out_date
);
  import bdc_pkg::*;

  // Stage A: clamp year and month, shift the year to start in March, divide by 25.
  logic [13:0] a_year_nxt, a_yp_nxt;
  logic [3:0]  a_month_nxt;
  logic        a_early;
  logic [26:0] a_prod_y, a_prod_yp;
  logic        a_valid_r;
  logic [13:0] a_year_r, a_yp_r;
  logic [3:0]  a_month_r;
  logic [4:0]  a_day_r;
  logic [9:0]  a_qy_r, a_qyp_r;

  always_comb begin
    if (year < YEAR_MIN) a_year_nxt = YEAR_MIN;
    else if (year > YEAR_MAX) a_year_nxt = YEAR_MAX;
    else a_year_nxt = year;
    if (month < MONTH_MIN) a_month_nxt = MONTH_MIN;
    else if (month > MONTH_MAX) a_month_nxt = MONTH_MAX;
    else a_month_nxt = month;
    a_early   = (a_month_nxt <= MONTH_FEB);
    a_yp_nxt  = a_year_nxt - 14'(a_early);
    a_prod_y  = 27'(a_year_nxt) * RECIP25;
    a_prod_yp = 27'(a_yp_nxt) * RECIP25;
  end

  // Stage B: leap year, day clamp, century correction and year part of the serial.
  logic [13:0] b_r25;
  logic        b_leap;
  logic [4:0]  b_lim, b_day_nxt;
  logic [11:0] b_l_nxt;
  logic        b_valid_r;
  logic [4:0]  b_day_r;
  logic [13:0] b_yp_r;
  logic [11:0] b_l_r;
  logic [21:0] b_base_r;
  logic [4:0]  b_wterm_r;
  logic [8:0]  b_sterm_r;

  always_comb begin
    b_r25  = a_year_r - 14'(a_qy_r) * 14'd25;
    b_leap = (a_year_r[1:0] == 2'd0) && ((b_r25 != 14'd0) || (a_year_r[3:0] == 4'd0));
    b_lim  = month_len(a_month_r, b_leap);
    if (a_day_r < DAY_MIN) b_day_nxt = DAY_MIN;
    else if (a_day_r > b_lim) b_day_nxt = b_lim;
    else b_day_nxt = a_day_r;
    b_l_nxt = 12'(a_yp_r >> 2) - 12'(a_qyp_r >> 2) + 12'(a_qyp_r >> 4);
  end

  // Stage C: final sums.
  bdc_date_t c_date_nxt;
  logic      c_valid_r;
  bdc_date_t c_date_r;

  always_comb begin
    c_date_nxt.serial = b_base_r + 22'(b_l_r) + 22'(b_sterm_r) + 22'(b_day_r);
    c_date_nxt.wsum   = 14'(b_day_r) + b_yp_r + 14'(b_l_r) + 14'(b_wterm_r);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_year_r  <= a_year_nxt;
    a_month_r <= a_month_nxt;
    a_day_r   <= day;
    a_yp_r    <= a_yp_nxt;
    a_qy_r    <= 10'(a_prod_y >> RECIP25_SHIFT);
    a_qyp_r   <= 10'(a_prod_yp >> RECIP25_SHIFT);
    b_day_r   <= b_day_nxt;
    b_yp_r    <= a_yp_r;
    b_l_r     <= b_l_nxt;
    b_base_r  <= 22'(a_yp_r) * DAYS_PER_YEAR;
    b_wterm_r <= wday_month_term(a_month_r);
    b_sterm_r <= serial_month_term(a_month_r);
    c_date_r  <= c_date_nxt;
  end

  assign out_valid = c_valid_r;
  assign out_date  = c_date_r;

endmodule

>>> design/business_day_counter.sv
// Top level of the business day counter: date units, span count and result register.
`timescale 1ns / 1ps
// Counts the days of an inclusive date span whose weekday is not set in the weekend
// mask, and reports the weekday of both dates. The block is a seven-stage pipeline: a
// query may be started in every cycle while busy is low, and its result appears on
// out_data with out_valid. busy is high during reset and in the first cycle after it.
// The receiver cannot stall, so a result must be taken in the one cycle that out_valid
// marks it. The user must write the weekend mask over the cfg channel while no query is
// in flight, which the block does not check; its reset value marks Friday and Saturday.
module business_day_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bdc_pkg::bdc_in_t   in_data,
  output logic               out_valid,
  output bdc_pkg::bdc_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import bdc_pkg::*;

  logic      busy_r;
  logic [6:0] mask_r;
  logic      accept;
  logic      from_valid, to_valid;
  bdc_date_t from_date, to_date;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // Control registers: busy after reset and the weekend mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      mask_r <= MASK_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) mask_r <= cfg_data;
    end
  end

  bdc_date u_from (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .year      (in_data.from_year),
    .month     (in_data.from_month),
    .day       (in_data.from_day),
    .out_valid (from_valid),
    .out_date  (from_date)
  );

  bdc_date u_to (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .year      (in_data.to_year),
    .month     (in_data.to_month),
    .day       (in_data.to_day),
    .out_valid (to_valid),
    .out_date  (to_date)
  );

  // Stage D: span length, order check and quotients of the weekday sums by seven.
  logic [27:0] d_prod_f, d_prod_t;
  logic        d_valid_r, d_ge_r;
  logic [13:0] d_wsum_f_r, d_wsum_t_r;
  logic [10:0] d_q7_f_r, d_q7_t_r;
  logic [21:0] d_n_r;

  always_comb begin
    d_prod_f = 28'(from_date.wsum) * RECIP7_S;
    d_prod_t = 28'(to_date.wsum) * RECIP7_S;
  end

  // Stage E: weekdays and whole weeks of the span.
  logic [13:0] e_rem_f, e_rem_t;
  logic [44:0] e_prod_n;
  logic        e_valid_r, e_ge_r;
  logic [2:0]  e_wd_f_r, e_wd_t_r;
  logic [21:0] e_n_r;
  logic [19:0] e_qn_r;

  always_comb begin
    e_rem_f  = d_wsum_f_r - 14'(d_q7_f_r) * 14'd7;
    e_rem_t  = d_wsum_t_r - 14'(d_q7_t_r) * 14'd7;
    e_prod_n = 45'(d_n_r) * RECIP7_W;
  end

  // Stage F: count over whole weeks and over the remaining days.
  logic [21:0] f_rem_n;
  logic        f_valid_r, f_ge_r;
  logic [2:0]  f_wd_f_r, f_wd_t_r, f_rem_r;
  logic [21:0] f_cw_r;

  assign f_rem_n = e_n_r - 22'(e_qn_r) * 22'd7;

  // Output stage.
  bdc_out_t out_nxt;
  logic     out_valid_r;
  bdc_out_t out_data_r;

  always_comb begin
    out_nxt.business_days = f_ge_r ? (f_cw_r + 22'(f_rem_r)) : 22'd0;
    out_nxt.from_weekday  = f_wd_f_r;
    out_nxt.to_weekday    = f_wd_t_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_valid_r   <= from_valid && to_valid;
      e_valid_r   <= d_valid_r;
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    d_wsum_f_r <= from_date.wsum;
    d_wsum_t_r <= to_date.wsum;
    d_q7_f_r   <= 11'(d_prod_f >> RECIP7_S_SHIFT);
    d_q7_t_r   <= 11'(d_prod_t >> RECIP7_S_SHIFT);
    d_ge_r     <= (from_date.serial <= to_date.serial);
    d_n_r      <= to_date.serial - from_date.serial + 22'd1;
    e_wd_f_r   <= e_rem_f[2:0];
    e_wd_t_r   <= e_rem_t[2:0];
    e_ge_r     <= d_ge_r;
    e_n_r      <= d_n_r;
    e_qn_r     <= 20'(e_prod_n >> RECIP7_W_SHIFT);
    f_wd_f_r   <= e_wd_f_r;
    f_wd_t_r   <= e_wd_t_r;
    f_ge_r     <= e_ge_r;
    f_cw_r     <= 22'(e_qn_r) * 22'(week_days(mask_r));
    f_rem_r    <= rem_count(e_wd_f_r, f_rem_n[2:0], mask_r);
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every transfer yields a result on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("result missing seven cycles after a transfer");

  // Weekdays and the remainder of the span stay below seven.
  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.from_weekday <= 3'd6) && (out_data.to_weekday <= 3'd6))
    else $error("weekday out of range");

  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r |-> (f_rem_n < 22'd7))
    else $error("remainder of span by seven out of range");

  // Nothing is issued in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result issued after reset");

endmodule
